[hw/rtl/edtb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtb_pkg
// shared types and codes for the edit distance core
// ----------------------------------------------------------------------------
package edtb_pkg;

  localparam logic [1:0] ACT_SRC = 2'd0;
  localparam logic [1:0] ACT_TGT = 2'd1;
  localparam logic [1:0] ACT_RUN = 2'd2;

  localparam logic [1:0] KIND_DELETE  = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_REPLACE = 2'd2;
  localparam logic [1:0] KIND_FINAL   = 2'd3;

  localparam logic [1:0] DIR_MATCH   = 2'd0;
  localparam logic [1:0] DIR_INSERT  = 2'd1;
  localparam logic [1:0] DIR_REPLACE = 2'd2;
  localparam logic [1:0] DIR_DELETE  = 2'd3;

  localparam int MAX_EDITS = 32;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
  } cmd_t;

endpackage

[hw/rtl/edtb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtb_queue
// small command queue between front and back
// ----------------------------------------------------------------------------
module edtb_queue
  import edtb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/edtb_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtb_engine
// string stores, table fill and traceback
// ----------------------------------------------------------------------------
module edtb_engine
  import edtb_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       strobe,
  output logic [1:0] kind,
  output logic [7:0] source_char,
  output logic [7:0] target_char,
  output logic [5:0] distance,
  output logic       last
);

  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DIM  = MAX_LEN + 1;
  localparam int TD   = DIM * DIM;
  localparam int TW   = $clog2(TD);
  localparam int CW   = $clog2(2 * MAX_LEN + 1);
  localparam int NW   = $clog2(MAX_EDITS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CALC  = 7'b0001000,
    S_TRD   = 7'b0010000,
    S_TSTEP = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0]    src_mem [MAX_LEN];
  logic [7:0]    tgt_mem [MAX_LEN];
  logic [CW-1:0] cost_mem [TD];
  logic [1:0]    dir_mem  [TD];

  logic [LW-1:0] src_len, tgt_len;
  logic [LW-1:0] i, j;
  logic [NW-1:0] n_edits;
  logic [CW-1:0] left_cost;    // cost at (i, j-1)
  logic [CW-1:0] diag_cost, up_cost;
  logic [CW-1:0] cost_q;
  logic [1:0]    dir_q;
  logic [7:0]    sc_q, tc_q;

  logic          cost_we, dir_we;
  logic [TW-1:0] wr_addr;
  logic [CW-1:0] wr_cost;
  logic [1:0]    wr_dir;
  logic [TW-1:0] rd_addr;
  logic          idle;

  function automatic logic [TW-1:0] idx(input logic [LW-1:0] r, input logic [LW-1:0] c);
    idx = TW'(r) * TW'(DIM) + TW'(c);
  endfunction

  logic [LW-1:0] im1, jm1;
  assign im1 = i - LW'(1);
  assign jm1 = j - LW'(1);

  // memories
  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[wr_addr] <= wr_cost;
    if (dir_we) dir_mem[wr_addr] <= wr_dir;
    cost_q <= cost_mem[rd_addr];
    dir_q  <= dir_mem[rd_addr];
  end

  // cell compute
  logic          diff;
  logic [CW-1:0] ca, cb, cc, cm;
  logic [1:0]    cd;
  always_comb begin
    diff = (sc_q != tc_q);
    ca = diag_cost + CW'(diff);
    cb = up_cost + CW'(1);
    cc = left_cost + CW'(1);
    cm = ca;
    cd = diff ? DIR_REPLACE : DIR_MATCH;
    if (cb < cm) begin
      cm = cb;
      cd = DIR_DELETE;
    end
    if (cc < cm) begin
      cm = cc;
      cd = DIR_INSERT;
    end
  end

  // phase within a cell read: 0 diag, 1 up
  logic rd_phase;

  always_comb begin
    cost_we = 1'b0;
    dir_we  = 1'b0;
    wr_addr = idx(i, j);
    wr_cost = '0;
    wr_dir  = DIR_MATCH;
    rd_addr = idx(i, j);
    case (state)
      S_INIT: begin
        cost_we = 1'b1;
        dir_we  = 1'b1;
        if (j == '0 && i == '0) begin
          wr_cost = '0;
          wr_dir  = DIR_MATCH;
        end else if (j == '0) begin
          wr_cost = CW'(i);
          wr_dir  = DIR_DELETE;
        end else begin
          wr_addr = idx('0, j);
          wr_cost = CW'(j);
          wr_dir  = DIR_INSERT;
        end
      end
      S_RD: rd_addr = rd_phase ? idx(im1, j) : idx(im1, jm1);
      S_CALC: begin
        cost_we = 1'b1;
        dir_we  = 1'b1;
        wr_cost = cm;
        wr_dir  = cd;
      end
      S_TRD: rd_addr = idx(i, j);
      S_FINAL: rd_addr = idx(i, j);
      default: ;
    endcase
  end

  assign idle    = (state == S_IDLE);
  assign cmd_pop = idle && cmd_valid;

  logic rd_wait;

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      src_len <= '0;
      tgt_len <= '0;
      i <= '0;
      j <= '0;
      n_edits <= '0;
      rd_phase <= 1'b0;
      rd_wait  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.action)
              ACT_SRC: if (src_len < LW'(MAX_LEN)) begin
                src_mem[src_len[AW-1:0]] <= cmd.symbol;
                src_len <= src_len + LW'(1);
              end
              ACT_TGT: if (tgt_len < LW'(MAX_LEN)) begin
                tgt_mem[tgt_len[AW-1:0]] <= cmd.symbol;
                tgt_len <= tgt_len + LW'(1);
              end
              ACT_RUN: begin
                i <= '0;
                j <= '0;
                n_edits <= '0;
                state <= S_INIT;
              end
              default: ;
            endcase
          end
        end
        // borders: column walk over i, then row walk over j
        S_INIT: begin
          if (j == '0 && i < src_len) begin
            i <= i + LW'(1);
          end else if (j < tgt_len) begin
            j <= j + LW'(1);
          end else if (src_len != '0 && tgt_len != '0) begin
            i <= LW'(1);
            j <= LW'(1);
            rd_phase <= 1'b0;
            rd_wait  <= 1'b0;
            left_cost <= CW'(1);
            state <= S_RD;
          end else begin
            i <= src_len;
            j <= tgt_len;
            rd_wait <= 1'b0;
            state <= S_TRD;
          end
        end
        S_RD: begin
          sc_q <= src_mem[im1[AW-1:0]];
          tc_q <= tgt_mem[jm1[AW-1:0]];
          if (!rd_phase) begin
            rd_phase <= 1'b1;
          end else if (!rd_wait) begin
            diag_cost <= cost_q;
            rd_wait <= 1'b1;
          end else begin
            up_cost  <= cost_q;
            rd_wait  <= 1'b0;
            rd_phase <= 1'b0;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (j < tgt_len) begin
            left_cost <= cm;
            j <= j + LW'(1);
            state <= S_RD;
          end else if (i < src_len) begin
            left_cost <= CW'(i + LW'(1));
            i <= i + LW'(1);
            j <= LW'(1);
            state <= S_RD;
          end else begin
            i <= src_len;
            j <= tgt_len;
            state <= S_TRD;
          end
        end
        S_TRD: begin
          if (i == '0 && j == '0) begin
            rd_wait <= 1'b0;
            i <= src_len;
            j <= tgt_len;
            state <= S_FINAL;
          end else if (!rd_wait) begin
            rd_wait <= 1'b1;
          end else begin
            rd_wait <= 1'b0;
            sc_q <= (i != '0) ? src_mem[im1[AW-1:0]] : 8'd0;
            tc_q <= (j != '0) ? tgt_mem[jm1[AW-1:0]] : 8'd0;
            state <= S_TSTEP;
          end
        end
        S_TSTEP: begin
          source_char <= 8'd0;
          target_char <= 8'd0;
          distance <= 6'd0;
          last <= 1'b0;
          case (dir_q)
            DIR_MATCH: begin
              if (i != '0) i <= im1;
              if (j != '0) j <= jm1;
            end
            DIR_INSERT: begin
              kind <= KIND_INSERT;
              target_char <= tc_q;
              j <= jm1;
            end
            DIR_DELETE: begin
              kind <= KIND_DELETE;
              source_char <= sc_q;
              i <= im1;
            end
            default: begin
              kind <= KIND_REPLACE;
              source_char <= sc_q;
              target_char <= tc_q;
              i <= im1;
              j <= jm1;
            end
          endcase
          if (dir_q != DIR_MATCH && n_edits < NW'(MAX_EDITS)) begin
            strobe <= 1'b1;
            n_edits <= n_edits + NW'(1);
          end
          state <= S_TRD;
        end
        S_FINAL: begin
          if (!rd_wait) begin
            rd_wait <= 1'b1;
          end else begin
            rd_wait <= 1'b0;
            strobe <= 1'b1;
            kind <= KIND_FINAL;
            source_char <= 8'd0;
            target_char <= 8'd0;
            distance <= 6'(cost_q);
            last <= 1'b1;
            src_len <= '0;
            tgt_len <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/edit_distance_with_traceback_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_with_traceback_core
// levenshtein distance with traceback of the edits
// ----------------------------------------------------------------------------
// append transactions (action 0/1) are taken by the engine while idle. a run
// fills the (sl+1)*(tl+1) cost table through the single table read port,
// then walks back and emits each edit, up to MAX_EDITS, as a one-cycle strobe
// (the receiver cannot stall), then the final distance with last set.
// a two-entry queue decouples acceptance; busy is high only while it is full
module edit_distance_with_traceback_core
  import edtb_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action,
  input  logic [7:0] symbol,
  output logic       strobe,
  output logic [1:0] kind,
  output logic [7:0] source_char,
  output logic [7:0] target_char,
  output logic [5:0] distance,
  output logic       last
);

  cmd_t in_cmd, q_cmd;
  logic q_full, q_valid, q_pop;
  logic accept;

  // front: take a transaction whenever the queue has space
  assign busy   = q_full;
  assign accept = start && !q_full;
  assign in_cmd = '{action: action, symbol: symbol};

  edtb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .not_empty (q_valid)
  );

  // back: stores, table fill and traceback
  edtb_engine #(.MAX_LEN(MAX_LEN)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (q_cmd),
    .cmd_pop     (q_pop),
    .strobe      (strobe),
    .kind        (kind),
    .source_char (source_char),
    .target_char (target_char),
    .distance    (distance),
    .last        (last)
  );

endmodule
